/* hdl/meab_pkg.sv */
// ----------------------------------------------------------------------------
// meab_pkg
// Shared constants and types for the mesh edge adjacency builder.
// ----------------------------------------------------------------------------
package meab_pkg;

  // table sizes and vertex width
  localparam int EDGE_CAP   = 1024;
  localparam int FACE_CAP   = 1024;
  localparam int VTX_W      = 16;

  localparam int EDGE_IDX_W = $clog2(EDGE_CAP);
  localparam int EDGE_CNT_W = EDGE_IDX_W + 1;
  localparam int FACE_W     = (FACE_CAP > 1) ? $clog2(FACE_CAP) : 1;
  localparam int FACE_CNT_W = FACE_W + 1;

  // result slot and face numbers travel in their low bits
  localparam int OUT_ID_W   = 10;

  // one edge table entry
  typedef struct packed {
    logic [VTX_W-1:0]  start_vtx;
    logic [VTX_W-1:0]  end_vtx;
    logic [FACE_W-1:0] owner;
    logic [FACE_W-1:0] nbr;
    logic              has_nbr;
  } edge_ent_t;

  localparam int ENT_W = $bits(edge_ent_t);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RES  = 3'b100
  } meab_state_t;

endpackage

/* hdl/meab_ram.sv */
// ----------------------------------------------------------------------------
// meab_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module meab_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mesh_edge_adjacency_builder_top.sv */
// ----------------------------------------------------------------------------
// mesh_edge_adjacency_builder_top
// Pairs face edges against a half-edge table held in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: a,b,c,d vertices; tuser: is_quad
//  out_     out  out_tvalid/out_tready tdata: slot, first, second face;
//                                      tuser: paired, overflow; tlast: last edge
//
//  Each edge scans the table one slot per cycle through the RAM read port.
//  A face is a triangle or a quad.
//  A rejected face (face counter full) skips the scan; each edge reports overflow.
//  Reset is synchronous; it clears the edge and face counts, not the RAM.
//  A stalled output holds the sequencer once a result is ready; the next face is taken while the
//  last beat of the previous one waits in the output register.
// ----------------------------------------------------------------------------
module mesh_edge_adjacency_builder_top
  import meab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // vertex_a, vertex_b, vertex_c, vertex_d
  input  logic        in_tuser,   // is_quad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // edge_slot, first_face, second_face, 2'b0
  output logic [1:0]  out_tuser,  // paired, overflow
  output logic        out_tlast   // last
);

  meab_state_t st_r, st_nxt;

  logic [VTX_W-1:0]      q_r [4];
  logic [VTX_W-1:0]      first_r;
  logic                  quad_r;
  logic [1:0]            k_r;
  logic [FACE_W-1:0]     face_r;
  logic                  rej_r;
  logic [EDGE_CNT_W-1:0] edge_total_r, edge_total_nxt;
  logic [FACE_CNT_W-1:0] face_total_r, face_total_nxt;
  logic [EDGE_CNT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic                  rv_r, rv_nxt;
  logic [EDGE_IDX_W-1:0] rv_slot_r;

  logic [OUT_ID_W-1:0]   res_slot_r, res_slot_nxt;
  logic                  res_paired_r, res_paired_nxt;
  logic [OUT_ID_W-1:0]   res_ff_r, res_ff_nxt;
  logic [OUT_ID_W-1:0]   res_sf_r, res_sf_nxt;
  logic                  res_ovf_r, res_ovf_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_ID_W-1:0]   out_slot_r, out_ff_r, out_sf_r;
  logic                  out_paired_r, out_ovf_r, out_last_r;

  logic                  in_acc, out_free, emit, is_last;
  logic                  face_full, edge_full, hit, issue, scan_done;
  logic [VTX_W-1:0]      u_vtx, v_vtx;

  logic                  ram_we;
  logic [EDGE_IDX_W-1:0] ram_waddr;
  edge_ent_t             ram_wdata, ram_rdata;

  // edge table
  meab_ram #(
    .DW    (ENT_W),
    .DEPTH (EDGE_CAP)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_addr_r[EDGE_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // handshake and current edge
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = (st_r == S_RES) && out_free;
  assign is_last   = quad_r ? (k_r == 2'd3) : (k_r == 2'd2);
  assign u_vtx     = q_r[0];
  assign v_vtx     = is_last ? first_r : q_r[1];
  assign face_full = (face_total_r >= FACE_CNT_W'(FACE_CAP));
  assign edge_full = (edge_total_r >= EDGE_CNT_W'(EDGE_CAP));

  // scan compare on returning read data
  assign hit = (st_r == S_SCAN) && rv_r && (ram_rdata.start_vtx == v_vtx) &&
               (ram_rdata.end_vtx == u_vtx) && !ram_rdata.has_nbr;
  assign issue     = (st_r == S_SCAN) && !hit && (rd_addr_r < edge_total_r);
  assign scan_done = (st_r == S_SCAN) && !rv_r && (rd_addr_r >= edge_total_r);

  // sequencer
  always_comb begin
    st_nxt         = st_r;
    edge_total_nxt = edge_total_r;
    face_total_nxt = face_total_r;
    rd_addr_nxt    = rd_addr_r;
    rv_nxt         = 1'b0;
    res_slot_nxt   = res_slot_r;
    res_paired_nxt = res_paired_r;
    res_ff_nxt     = res_ff_r;
    res_sf_nxt     = res_sf_r;
    res_ovf_nxt    = res_ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = edge_total_r[EDGE_IDX_W-1:0];
    ram_wdata      = '{start_vtx: u_vtx, end_vtx: v_vtx, owner: face_r,
                       nbr: '0, has_nbr: 1'b0};
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_addr_nxt = '0;
          if (face_full) begin
            res_slot_nxt   = '0;
            res_paired_nxt = 1'b0;
            res_ff_nxt     = '0;
            res_sf_nxt     = '0;
            res_ovf_nxt    = 1'b1;
            st_nxt         = S_RES;
          end else begin
            face_total_nxt = face_total_r + 1'b1;
            st_nxt         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          // pair with the first open reversed edge
          ram_we         = 1'b1;
          ram_waddr      = rv_slot_r;
          ram_wdata      = '{start_vtx: ram_rdata.start_vtx,
                             end_vtx: ram_rdata.end_vtx, owner: ram_rdata.owner,
                             nbr: face_r, has_nbr: 1'b1};
          res_slot_nxt   = OUT_ID_W'(rv_slot_r);
          res_paired_nxt = 1'b1;
          res_ff_nxt     = OUT_ID_W'(ram_rdata.owner);
          res_sf_nxt     = OUT_ID_W'(face_r);
          res_ovf_nxt    = 1'b0;
          st_nxt         = S_RES;
        end else if (scan_done) begin
          res_paired_nxt = 1'b0;
          res_ff_nxt     = OUT_ID_W'(face_r);
          res_sf_nxt     = '0;
          if (edge_full) begin
            res_slot_nxt = '0;
            res_ovf_nxt  = 1'b1;
          end else begin
            // append a new open edge
            ram_we         = 1'b1;
            edge_total_nxt = edge_total_r + 1'b1;
            res_slot_nxt   = OUT_ID_W'(edge_total_r);
            res_ovf_nxt    = 1'b0;
          end
          st_nxt = S_RES;
        end else begin
          rv_nxt = issue;
          if (issue) begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
      end
      S_RES: begin
        if (emit) begin
          rd_addr_nxt = '0;
          if (is_last) begin
            st_nxt = S_IDLE;
          end else if (!rej_r) begin
            st_nxt = S_SCAN;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // output register
  assign out_valid_nxt = emit || (out_valid_r && !out_tready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      edge_total_r <= '0;
      face_total_r <= '0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      edge_total_r <= edge_total_nxt;
      face_total_r <= face_total_nxt;
      rv_r         <= rv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    res_slot_r   <= res_slot_nxt;
    res_paired_r <= res_paired_nxt;
    res_ff_r     <= res_ff_nxt;
    res_sf_r     <= res_sf_nxt;
    res_ovf_r    <= res_ovf_nxt;
    if (issue) begin
      rv_slot_r <= rd_addr_r[EDGE_IDX_W-1:0];
    end
    if (in_acc) begin
      q_r[0]  <= in_tdata[VTX_W-1:0];
      q_r[1]  <= in_tdata[16+VTX_W-1:16];
      q_r[2]  <= in_tdata[32+VTX_W-1:32];
      q_r[3]  <= in_tdata[48+VTX_W-1:48];
      first_r <= in_tdata[VTX_W-1:0];
      quad_r  <= in_tuser;
      k_r     <= 2'd0;
      face_r  <= face_total_r[FACE_W-1:0];
      rej_r   <= face_full;
    end else if (emit) begin
      // step to the next edge in winding order
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
      q_r[2] <= q_r[3];
      k_r    <= k_r + 2'd1;
    end
    if (emit) begin
      out_slot_r   <= res_slot_r;
      out_paired_r <= res_paired_r;
      out_ff_r     <= res_ff_r;
      out_sf_r     <= res_sf_r;
      out_ovf_r    <= res_ovf_r;
      out_last_r   <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sf_r, out_ff_r, out_slot_r};
  assign out_tuser  = {out_ovf_r, out_paired_r};
  assign out_tlast  = out_last_r;

endmodule

/* hdl/meab_checker.sv */
// ----------------------------------------------------------------------------
// meab_checker
// Port-level checks for the mesh edge adjacency builder, bound to the top.
// ----------------------------------------------------------------------------
module meab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a face is taken one at a time: ready drops right after an input beat
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready stayed high after an accepted face");

  // a stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a paired edge never reports overflow
  a_pair_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("paired and overflow both set");

  // a dropped edge carries no slot and no second face
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[9:0] == 10'd0 &&
    out_tdata[29:20] == 10'd0)
    else $error("overflow beat with nonzero slot or second face");

  // an unpaired edge has no second face
  a_new_sf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[29:20] == 10'd0)
    else $error("unpaired edge with second face set");

endmodule

bind mesh_edge_adjacency_builder_top meab_checker u_meab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* test/meab_edge_checker.sv */
// ----------------------------------------------------------------------------
// meab_edge_checker
// Watches both channels of the mesh edge adjacency builder. For every face
// that is accepted it works out the edge beats the block must give, using its
// own half-edge table. Each output beat is compared with the oldest beat that
// is still expected.
// ----------------------------------------------------------------------------
module meab_edge_checker
  import meab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,    // vertex_a, vertex_b, vertex_c, vertex_d
  input  logic        in_tuser,    // is_quad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // edge_slot, first_face, second_face, 2'b0
  input  logic [1:0]  out_tuser,   // paired, overflow
  input  logic        out_tlast,   // last
  output int          mismatches,
  output int          beats_due,
  output int          beats_seen,
  output int          pairs_seen,
  output int          drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // one edge beat as the block reports it
  typedef struct packed {
    logic [OUT_ID_W-1:0] slot;
    logic                paired;
    logic [OUT_ID_W-1:0] owner;
    logic [OUT_ID_W-1:0] partner;
    logic                dropped;
    logic                tail;
  } edge_beat_t;

  // half-edge table as predicted
  logic [VTX_W-1:0]  tab_from   [EDGE_CAP];
  logic [VTX_W-1:0]  tab_to     [EDGE_CAP];
  logic [FACE_W-1:0] tab_owner  [EDGE_CAP];
  logic              tab_linked [EDGE_CAP];
  int                edge_count;
  int                face_count;
  edge_beat_t        beats_pending[$];

  function automatic string show(edge_beat_t b);
    return $sformatf("slot=%0d paired=%0b first=%0d second=%0d ovf=%0b last=%0b",
                     b.slot, b.paired, b.owner, b.partner, b.dropped, b.tail);
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $time, msg);
  endfunction

  // pair edge u->v with the first open v->u, else append it (or drop it)
  function automatic edge_beat_t pair_or_append(int face, logic [VTX_W-1:0] u,
                                                logic [VTX_W-1:0] v, logic tail);
    edge_beat_t b;
    b = '0;
    b.tail = tail;
    for (int i = 0; i < edge_count; i++) begin
      if (tab_from[i] == v && tab_to[i] == u && !tab_linked[i]) begin
        tab_linked[i] = 1'b1;
        b.slot = OUT_ID_W'(i);
        b.paired = 1'b1;
        b.owner = OUT_ID_W'(tab_owner[i]);
        b.partner = OUT_ID_W'(face);
        return b;
      end
    end
    b.owner = OUT_ID_W'(face);
    // table full: the edge is lost, the face still counts
    if (edge_count >= EDGE_CAP) begin
      b.dropped = 1'b1;
      return b;
    end
    tab_from[edge_count] = u;
    tab_to[edge_count] = v;
    tab_owner[edge_count] = FACE_W'(face);
    tab_linked[edge_count] = 1'b0;
    b.slot = OUT_ID_W'(edge_count);
    edge_count++;
    return b;
  endfunction

  // expected beats of one face, in winding order
  task automatic predict_face(input logic [63:0] data, input logic quad);
    logic [VTX_W-1:0] vtx [4];
    edge_beat_t b;
    int n;
    int face;
    n = quad ? 4 : 3;
    for (int k = 0; k < 4; k++) vtx[k] = data[16*k +: VTX_W];
    if (face_count >= FACE_CAP) begin
      // face counter full: no number is given, every edge is dropped
      for (int k = 0; k < n; k++) begin
        b = '0;
        b.dropped = 1'b1;
        b.tail = (k == n - 1);
        beats_pending.push_back(b);
      end
    end else begin
      face = face_count;
      face_count++;
      for (int k = 0; k < n; k++) begin
        b = pair_or_append(face, vtx[k], vtx[(k + 1) % n], k == n - 1);
        beats_pending.push_back(b);
      end
    end
  endtask

  task automatic check_beat();
    edge_beat_t got;
    edge_beat_t want;
    got.slot = out_tdata[OUT_ID_W-1:0];
    got.owner = out_tdata[2*OUT_ID_W-1:OUT_ID_W];
    got.partner = out_tdata[3*OUT_ID_W-1:2*OUT_ID_W];
    got.paired = out_tuser[0];
    got.dropped = out_tuser[1];
    got.tail = out_tlast;
    beats_seen++;
    if (got.paired === 1'b1) pairs_seen++;
    if (got.dropped === 1'b1) drops_seen++;
    if (beats_pending.size() == 0) begin
      log_mismatch($sformatf("beat with nothing expected: %s", show(got)));
    end else begin
      want = beats_pending.pop_front();
      if (got !== want)
        log_mismatch($sformatf("beat %0d expected %s got %s", beats_seen,
                               show(want), show(got)));
    end
  endtask

  // inputs are predicted before outputs are checked within one edge
  always @(posedge clk) begin
    if (!rst_n) begin
      edge_count = 0;
      face_count = 0;
      beats_pending.delete();
    end else begin
      if (in_tvalid && in_tready) predict_face(in_tdata, in_tuser);
      if (out_tvalid && out_tready) check_beat();
    end
    beats_due <= beats_pending.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives faces into the mesh edge adjacency builder and gives the verdict.
// A short directed set covers pairing, re-pairing and degenerate edges; random
// faces built around shared vertices follow, under three stall profiles.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import meab_pkg::*;

  localparam int          WATCHDOG_CYCLES = 20000;
  localparam int          RANDOM_FACES    = 124;
  localparam logic [15:0] POOL_BASE       = 16'h4000;

  typedef struct packed {
    logic        quad;
    logic [15:0] d;
    logic [15:0] c;
    logic [15:0] b;
    logic [15:0] a;
  } face_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int    mismatches;
  int    beats_due;
  int    beats_seen;
  int    pairs_seen;
  int    drops_seen;
  int    src_gap_pct = 0;
  int    sink_stall_pct = 0;
  int    faces_sent = 0;
  int    quiet_cycles = 0;
  face_t recent[$];

  always #10 clk = ~clk;

  mesh_edge_adjacency_builder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  meab_edge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .mismatches(mismatches),
    .beats_due (beats_due),
    .beats_seen(beats_seen),
    .pairs_seen(pairs_seen),
    .drops_seen(drops_seen)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("no beat for %0d cycles", WATCHDOG_CYCLES);
      $display("[mesh_edge_adjacency_builder_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic face_t make_face(logic [15:0] a, logic [15:0] b,
                                      logic [15:0] c, logic [15:0] d, logic quad);
    face_t f;
    f.a = a;
    f.b = b;
    f.c = c;
    f.d = d;
    f.quad = quad;
    return f;
  endfunction

  function automatic logic [15:0] pool_vtx();
    return POOL_BASE + 16'($urandom_range(11));
  endfunction

  // new face across one edge of an earlier face
  function automatic face_t neighbor_of(face_t h);
    logic [15:0] v [4];
    int n;
    int k;
    v[0] = h.a;
    v[1] = h.b;
    v[2] = h.c;
    v[3] = h.d;
    n = h.quad ? 4 : 3;
    k = $urandom_range(n - 1);
    return make_face(v[(k + 1) % n], v[k], pool_vtx(), pool_vtx(),
                     1'($urandom_range(1)));
  endfunction

  // same face with reversed winding: all edges can pair
  function automatic face_t flipped(face_t h);
    face_t f;
    f = h;
    if (h.quad) begin
      f.b = h.d;
      f.d = h.b;
    end else begin
      f.b = h.c;
      f.c = h.b;
    end
    return f;
  endfunction

  // one input beat; valid stays up across back-to-back beats
  task automatic push_face(face_t f);
    if ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    in_tdata <= {f.d, f.c, f.b, f.a};
    in_tuser <= f.quad;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    faces_sent++;
    recent.push_back(f);
    if (recent.size() > 24) recent.delete(0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
  endtask

  task automatic run_directed();
    // degenerate faces, all-zero and all-one vertices
    push_face(make_face(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
    push_face(make_face(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // pair, then a reversed edge whose partner is already taken
    push_face(make_face(16'h0001, 16'h0002, 16'h0003, 16'h0000, 1'b0));
    push_face(make_face(16'h0002, 16'h0001, 16'h0004, 16'h0000, 1'b0));
    push_face(make_face(16'h0002, 16'h0001, 16'h0005, 16'h0000, 1'b0));
    push_face(make_face(16'h0001, 16'h0002, 16'h0006, 16'h0000, 1'b0));
    // quad fully closed by its mirror
    push_face(make_face(16'h0010, 16'h0011, 16'h0012, 16'h0013, 1'b1));
    push_face(make_face(16'h0011, 16'h0010, 16'h0013, 16'h0012, 1'b1));
    // two open copies of one edge: the lower slot pairs first
    push_face(make_face(16'h0020, 16'h0021, 16'h0022, 16'hFFFF, 1'b0));
    push_face(make_face(16'h0020, 16'h0021, 16'h0023, 16'h0000, 1'b0));
    push_face(make_face(16'h0021, 16'h0020, 16'h0024, 16'h0000, 1'b0));
    push_face(make_face(16'h0021, 16'h0020, 16'h0025, 16'h0000, 1'b0));
    // extremes mixed within a face
    push_face(make_face(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    push_face(make_face(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));
    push_face(make_face(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1));
    push_face(make_face(16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE, 1'b0));
    push_face(make_face(16'h3A00, 16'h3A01, 16'h3A02, 16'h0000, 1'b0));
  endtask

  // mostly faces that share edges with recent ones, some pure noise
  task automatic run_random(int count);
    face_t f;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 20 || recent.size() == 0)
        f = {1'($urandom_range(1)), $urandom, $urandom};
      else if (pick < 65)
        f = neighbor_of(recent[$urandom_range(recent.size() - 1)]);
      else if (pick < 75)
        f = flipped(recent[$urandom_range(recent.size() - 1)]);
      else
        f = make_face(pool_vtx(), pool_vtx(), pool_vtx(), pool_vtx(),
                      1'($urandom_range(1)));
      push_face(f);
    end
  endtask

  initial begin
    src_gap_pct = 34;
    sink_stall_pct = 78;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_FACES / 3);
    wait_drained();
    src_gap_pct = 78;
    sink_stall_pct = 34;
    run_random(RANDOM_FACES / 3);
    wait_drained();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    run_random(RANDOM_FACES - 2 * (RANDOM_FACES / 3));
    wait_drained();
    // catch any stray beat after the last expected one
    repeat (4 * (EDGE_CAP + 8)) @(posedge clk);
    $display("faces sent: %0d, directed and random, under three stall profiles",
             faces_sent);
    $display("edge beats checked: %0d, paired %0d, dropped %0d",
             beats_seen, pairs_seen, drops_seen);
    if (mismatches == 0 && beats_due == 0)
      $display("[mesh_edge_adjacency_builder_top] OK");
    else
      $display("[mesh_edge_adjacency_builder_top] ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/meab_pkg.sv
hdl/meab_ram.sv
hdl/mesh_edge_adjacency_builder_top.sv
hdl/meab_checker.sv
test/meab_edge_checker.sv
test/tb.sv
